### sv/multi_gaussian_background_model_defines.svh
// Assertion macros for the multi-Gaussian background model.
`ifndef MULTI_GAUSSIAN_BACKGROUND_MODEL_DEFINES_SVH
`define MULTI_GAUSSIAN_BACKGROUND_MODEL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MGBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MGBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mgbm_pkg.sv
// Types, constants and helper functions shared by the multi-Gaussian model blocks.
package mgbm_pkg;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic [1:0] CFG_GAUSS_COUNT   = 2'd0;
  localparam logic [1:0] CFG_DERIVS_ENABLE = 2'd1;

  localparam int EXP_STEPS = 1024;
  localparam logic [63:0] EXP_RATIO_Q30 = 64'd1057095000;
  localparam logic [63:0] Q48_POS_MAX   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] Q48_NEG_MAG   = 64'h0000_8000_0000_0000;
  localparam logic [47:0] ONE_Q16       = 48'd65536;

  typedef struct packed {
    logic               func;
    logic [5:0]         param_index;
    logic signed [31:0] param_value;
    logic signed [31:0] x_value;
  } in_t;

  typedef struct packed {
    logic signed [47:0] model_value;
    logic [5:0]         deriv_index;
    logic signed [47:0] deriv_value;
    logic               last;
  } out_t;

  typedef logic [31:0] exp_tab_t [0:EXP_STEPS];

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_START, OP_RD_A, OP_RD_C, OP_RD_W, OP_CAP_W, OP_CHECK,
    OP_DIV1, OP_MUL_ZZ, OP_TAB, OP_MUL_INT, OP_KERN, OP_MUL_AK, OP_SUM,
    OP_MUL_MZ, OP_DIV2_GO, OP_DIV2, OP_MUL_LO, OP_MUL_HI, OP_P2, OP_WR_DA,
    OP_WR_DC, OP_WR_DW, OP_BG_RD, OP_BG, OP_EMIT_RD, OP_EMIT_LD
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_A, ST_RD_C, ST_RD_W, ST_CAP_W, ST_CHECK, ST_DIV1,
    ST_MUL_ZZ, ST_TAB, ST_MUL_INT, ST_KERN, ST_MUL_AK, ST_SUM, ST_MUL_MZ,
    ST_DIV2_GO, ST_DIV2, ST_MUL_LO, ST_MUL_HI, ST_P2, ST_WR_DA, ST_WR_DC,
    ST_WR_DW, ST_BG_RD, ST_BG, ST_EMIT_RD, ST_EMIT_LD
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic tail_skip;
    logic kern_zero;
    logic comp_last;
    logic n_zero;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  function automatic exp_tab_t exp_build();
    exp_tab_t    t;
    logic [63:0] v;
    v = 64'd1 << 30;
    for (int i = 0; i <= EXP_STEPS; i++) begin
      t[i] = v[31:0];
      v = (v * EXP_RATIO_Q30 + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_build();

  function automatic logic [47:0] pack48(input logic neg, input logic [63:0] mag);
    logic [63:0] lim;
    logic [63:0] sel;
    logic [63:0] dif;
    lim = neg ? Q48_NEG_MAG : Q48_POS_MAX;
    sel = (mag > lim) ? lim : mag;
    dif = 64'd0 - sel;
    return neg ? dif[47:0] : sel[47:0];
  endfunction

endpackage

### sv/mgbm_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module mgbm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] div_r, div_nxt;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    trial    = {rem_r, dvd_r[63]};
    diff     = trial - {1'b0, div_r};
    ge       = trial >= {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = 32'd0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : trial[31:0];
      dvd_nxt = {dvd_r[62:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;
endmodule

### sv/mgbm_ctrl.sv
// Sequencer for loads, per-component evaluation and result emission.
module mgbm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_func,
  output logic                 in_stall,
  input  mgbm_pkg::dp_status_t status,
  output mgbm_pkg::dp_cmd_t    cmd
);
  import mgbm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_func == FUNC_EVAL) begin
            cmd.op    = OP_START;
            state_nxt = status.n_zero ? ST_BG_RD : ST_RD_A;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      ST_RD_A: begin
        cmd.op    = OP_RD_A;
        state_nxt = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.op    = OP_RD_C;
        state_nxt = ST_RD_W;
      end
      ST_RD_W: begin
        cmd.op    = OP_RD_W;
        state_nxt = ST_CAP_W;
      end
      ST_CAP_W: begin
        cmd.op    = OP_CAP_W;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = status.tail_skip ? ST_MUL_AK : ST_DIV1;
      end
      ST_DIV1: begin
        cmd.op = OP_DIV1;
        if (status.div_done) begin
          state_nxt = ST_MUL_ZZ;
        end
      end
      ST_MUL_ZZ: begin
        cmd.op    = OP_MUL_ZZ;
        state_nxt = ST_TAB;
      end
      ST_TAB: begin
        cmd.op    = OP_TAB;
        state_nxt = ST_MUL_INT;
      end
      ST_MUL_INT: begin
        cmd.op    = OP_MUL_INT;
        state_nxt = ST_KERN;
      end
      ST_KERN: begin
        cmd.op    = OP_KERN;
        state_nxt = ST_MUL_AK;
      end
      ST_MUL_AK: begin
        cmd.op    = OP_MUL_AK;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = status.kern_zero ? ST_WR_DA : ST_MUL_MZ;
      end
      ST_MUL_MZ: begin
        cmd.op    = OP_MUL_MZ;
        state_nxt = ST_DIV2_GO;
      end
      ST_DIV2_GO: begin
        cmd.op    = OP_DIV2_GO;
        state_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        cmd.op = OP_DIV2;
        if (status.div_done) begin
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.op    = OP_MUL_LO;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.op    = OP_MUL_HI;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        cmd.op    = OP_P2;
        state_nxt = ST_WR_DA;
      end
      ST_WR_DA: begin
        cmd.op    = OP_WR_DA;
        state_nxt = ST_WR_DC;
      end
      ST_WR_DC: begin
        cmd.op    = OP_WR_DC;
        state_nxt = ST_WR_DW;
      end
      ST_WR_DW: begin
        cmd.op    = OP_WR_DW;
        state_nxt = status.comp_last ? ST_BG_RD : ST_RD_A;
      end
      ST_BG_RD: begin
        cmd.op    = OP_BG_RD;
        state_nxt = ST_BG;
      end
      ST_BG: begin
        cmd.op    = OP_BG;
        state_nxt = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        cmd.op    = OP_EMIT_RD;
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd.op = OP_EMIT_LD;
        if (status.out_free) begin
          state_nxt = status.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

### sv/mgbm_dp.sv
// Datapath: parameter and derivative memories, shared multiplier, divider, output register.
module mgbm_dp #(
  parameter int MAX_GAUSS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mgbm_pkg::in_t        in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [4:0]           cfg_wdata,
  input  mgbm_pkg::dp_cmd_t    cmd,
  output mgbm_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mgbm_pkg::out_t       out_data
);
  import mgbm_pkg::*;

  localparam int NPARAM = 3 * MAX_GAUSS + 1;
  localparam int AW     = $clog2(NPARAM);
  localparam int KW     = $clog2(MAX_GAUSS + 1);

  logic [31:0] prm_mem [NPARAM];
  logic [47:0] drv_mem [NPARAM];

  logic [4:0]    gc_r;
  logic          de_r;
  logic          out_valid_r;
  out_t          out_r;

  logic [31:0]   prm_q_r;
  logic [47:0]   drv_q_r;
  logic [KW-1:0] k_r;
  logic [AW-1:0] j_r;
  logic signed [31:0] x_r, a_r, c_r;
  logic [32:0]   dm_r;
  logic [31:0]   wm_r, am_r, m_r;
  logic          sa_r, sd_r, sw_r, far_r;
  logic [30:0]   zq_r, kern_r, ta_r, tb_r;
  logic [29:0]   frac_r;
  logic [63:0]   prod_r, lo_r, p1_r, p2_r;
  logic signed [39:0] sum_r;

  logic [KW-1:0] n_eff;
  logic [5:0]    k3, k3p1, k3p2, n3;
  logic          prm_re;
  logic [5:0]    prm_raddr;
  logic          drv_we;
  logic [5:0]    drv_waddr;
  logic [47:0]   drv_wdata;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;
  logic          div_start, div_done;
  logic [63:0]   div_dvd, div_q;
  logic          skip;
  logic          out_free;
  logic signed [32:0] d_s;
  logic [32:0]   d_neg;
  logic [31:0]   w_neg, a_neg;
  logic [95:0]   full;
  logic [39:0]   m_ext;
  logic [30:0]   tab_diff;
  logic [9:0]    tidx;
  logic [10:0]   tidx1;
  logic signed [39:0] bg_ext;

  mgbm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (wm_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    n_eff = (gc_r > 5'(MAX_GAUSS)) ? KW'(MAX_GAUSS) : gc_r[KW-1:0];
    k3    = 6'(k_r) * 6'd3;
    k3p1  = k3 + 6'd1;
    k3p2  = k3 + 6'd2;
    n3    = 6'(n_eff) * 6'd3;
    skip  = (wm_r == 32'd0) || ({4'd0, dm_r} >= {wm_r, 5'd0});
    out_free = !out_valid_r || !out_stall;
    d_s   = {x_r[31], x_r} - {c_r[31], c_r};
    d_neg = 33'd0 - d_s;
    w_neg = 32'd0 - prm_q_r;
    a_neg = 32'd0 - a_r;
    full  = {prod_r, 32'd0} + {32'd0, lo_r};
    m_ext = {8'd0, prod_r[61:30]};
    tab_diff = ta_r - tb_r;
    tidx  = prod_r[56:47];
    tidx1 = {1'b0, tidx} + 11'd1;
    bg_ext = {{8{prm_q_r[31]}}, prm_q_r};

    prm_re    = 1'b0;
    prm_raddr = k3;
    unique case (cmd.op)
      OP_RD_A:  prm_re = 1'b1;
      OP_RD_C: begin
        prm_re    = 1'b1;
        prm_raddr = k3p1;
      end
      OP_RD_W: begin
        prm_re    = 1'b1;
        prm_raddr = k3p2;
      end
      OP_BG_RD: begin
        prm_re    = 1'b1;
        prm_raddr = n3;
      end
      default: prm_re = 1'b0;
    endcase

    drv_we    = 1'b0;
    drv_waddr = k3;
    drv_wdata = pack48(1'b0, 64'(kern_r >> 14));
    unique case (cmd.op)
      OP_WR_DA: drv_we = 1'b1;
      OP_WR_DC: begin
        drv_we    = 1'b1;
        drv_waddr = k3p1;
        drv_wdata = pack48(sa_r ^ sd_r, p1_r >> 10);
      end
      OP_WR_DW: begin
        drv_we    = 1'b1;
        drv_waddr = k3p2;
        drv_wdata = pack48(sa_r ^ sw_r, p2_r);
      end
      OP_BG: begin
        drv_we    = 1'b1;
        drv_waddr = n3;
        drv_wdata = ONE_Q16;
      end
      default: drv_we = 1'b0;
    endcase

    mul_a = {1'b0, zq_r};
    mul_b = {1'b0, zq_r};
    unique case (cmd.op)
      OP_MUL_INT: begin
        mul_a = {1'b0, tab_diff};
        mul_b = {2'd0, frac_r};
      end
      OP_MUL_AK: begin
        mul_a = am_r;
        mul_b = {1'b0, kern_r};
      end
      OP_MUL_MZ: mul_a = m_r;
      OP_MUL_LO: mul_a = p1_r[31:0];
      OP_MUL_HI: mul_a = p1_r[63:32];
      default:   mul_a = {1'b0, zq_r};
    endcase
    mul_p = mul_a * mul_b;

    div_start = 1'b0;
    div_dvd   = prod_r;
    if (cmd.op == OP_CHECK) begin
      div_start = !skip;
      div_dvd   = {5'd0, dm_r, 26'd0};
    end else if (cmd.op == OP_DIV2_GO) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && {1'b0, in_data.param_index} < 7'(NPARAM)) begin
      prm_mem[in_data.param_index[AW-1:0]] <= in_data.param_value;
    end
    if (prm_re) begin
      prm_q_r <= prm_mem[prm_raddr[AW-1:0]];
    end
    if (drv_we) begin
      drv_mem[drv_waddr[AW-1:0]] <= drv_wdata;
    end
    if (cmd.op == OP_EMIT_RD) begin
      drv_q_r <= drv_mem[j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r        <= 5'd1;
      de_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_GAUSS_COUNT) begin
        gc_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_DERIVS_ENABLE) begin
        de_r <= cfg_wdata[0];
      end
      if (cmd.op == OP_EMIT_LD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_START: begin
        x_r   <= in_data.x_value;
        k_r   <= '0;
        j_r   <= '0;
        sum_r <= '0;
      end
      OP_RD_C: a_r <= prm_q_r;
      OP_RD_W: c_r <= prm_q_r;
      OP_CAP_W: begin
        dm_r <= d_s[32] ? d_neg : d_s;
        wm_r <= prm_q_r[31] ? w_neg : prm_q_r;
        am_r <= a_r[31] ? a_neg : a_r;
        sa_r <= a_r[31];
        sd_r <= d_s[32];
        sw_r <= prm_q_r[31];
      end
      OP_CHECK: begin
        zq_r   <= '0;
        kern_r <= '0;
      end
      OP_DIV1: begin
        if (div_done) begin
          zq_r <= div_q[30:0];
        end
      end
      OP_MUL_ZZ, OP_MUL_INT, OP_MUL_AK, OP_MUL_MZ, OP_MUL_HI: prod_r <= mul_p;
      OP_MUL_LO: lo_r <= mul_p;
      OP_TAB: begin
        far_r  <= prod_r[63:57] != 7'd0;
        ta_r   <= EXP_TAB[11'(tidx)][30:0];
        tb_r   <= EXP_TAB[tidx1][30:0];
        frac_r <= prod_r[46:17];
      end
      OP_KERN: kern_r <= far_r ? 31'd0 : ta_r - {1'b0, prod_r[59:30]};
      OP_SUM: begin
        m_r   <= prod_r[61:30];
        sum_r <= sa_r ? sum_r - $signed(m_ext) : sum_r + $signed(m_ext);
        p1_r  <= '0;
        p2_r  <= '0;
      end
      OP_DIV2: begin
        if (div_done) begin
          p1_r <= div_q;
        end
      end
      OP_P2: p2_r <= (full[95:64] != 32'd0) ? '1 : {36'd0, full[63:36]};
      OP_WR_DW: k_r <= k_r + KW'(1);
      OP_BG: sum_r <= sum_r + bg_ext;
      OP_EMIT_LD: begin
        if (out_free) begin
          out_r.model_value <= {{8{sum_r[39]}}, sum_r};
          out_r.deriv_index <= de_r ? 6'(j_r) : 6'd0;
          out_r.deriv_value <= de_r ? drv_q_r : 48'd0;
          out_r.last        <= status.emit_last;
          j_r               <= j_r + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.div_done  = div_done;
    status.tail_skip = skip;
    status.kern_zero = kern_r == 31'd0;
    status.comp_last = ({1'b0, k_r} + (KW + 1)'(1)) >= {1'b0, n_eff};
    status.n_zero    = n_eff == '0;
    status.emit_last = !de_r || (6'(j_r) == n3);
    status.out_free  = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

### sv/multi_gaussian_background_model.sv
// Top level of the multi-Gaussian background model evaluator.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall    mgbm_pkg::in_t
//   out_     output     out_valid / out_stall  mgbm_pkg::out_t
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// A load writes one parameter slot and the block stays idle. A sample is accepted,
// then each component is evaluated, two divider passes dominating (the second is
// skipped for a zero kernel, both past the tail or for a zero width), then the
// background is added and the results are emitted. Reset is synchronous and needs
// no clearing pass; parameter slots are undefined until loaded. out_stall holds the
// output register and the sequencer waits on it; input is taken only while idle.
`include "multi_gaussian_background_model_defines.svh"

module multi_gaussian_background_model #(
  parameter int MAX_GAUSS = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mgbm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mgbm_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [4:0]     cfg_wdata
);
  import mgbm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mgbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mgbm_dp #(
    .MAX_GAUSS (MAX_GAUSS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `MGBM_ASSERT_NEXT(a_eval_busy, in_valid && !in_stall && in_data.func == FUNC_EVAL, in_stall, "sample transaction did not start evaluation")
  `MGBM_ASSERT_NEXT(a_load_idle, in_valid && !in_stall && in_data.func == FUNC_LOAD, !in_stall, "load transaction left the block busy")
  `MGBM_ASSERT_NOW(a_partial_busy, out_valid && !out_data.last, in_stall, "input taken before last result was queued")
endmodule
